[rtl/cfp_pkg.sv]
// Shared types and constants for the checksum frame parser.
`default_nettype none

package cfp_pkg;

	// Seed of the additive checksum at the start of every frame.
	localparam logic [7:0] SUM_SEED = 8'hFF;

	// Kind of result word seen on the output side.
	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} kind_t;

	// Operation handed from the classifying front end to the back end.
	typedef struct packed {
		kind_t      kind;    // payload byte or checksum byte
		logic [7:0] data;    // received byte
		logic       last;    // final payload byte of the frame
		logic [7:0] length;  // announced payload length
	} op_t;

endpackage : cfp_pkg

`default_nettype wire

[rtl/checksum_frame_parser_top.sv]
// Top level of the checksum frame parser.
//
// Input side: a queue-style channel. A received byte on rx_byte is taken at a
// rising edge with push high and full low. Each frame is a start byte, a length
// byte, that many payload bytes, a checksum byte and an end byte.
// Output side: a queue-style channel. While empty is low the oldest result word
// is on kind, payload_byte, last_payload, checksum_bad and frame_length, and it
// is taken at a rising edge with pop high and empty low. Payload bytes come out
// as they arrive; the checksum byte gives a status word.
// Throughput is one byte per cycle while full is low, set by the combinational
// classification in the front end and the checksum register in the back end.
// A byte's result passes the operation queue and output register before a pop.
// When the receiver stalls, results gather in the operation queue (QDEPTH words)
// and the output register; full rises once the queue is full.
// Reset (arst_n low) empties both sides and returns the parser to waiting for a
// start byte with the checksum seeded to 0xFF.
`default_nettype none

module checksum_frame_parser_top
	import cfp_pkg::*;
#(
	parameter int QDEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	output logic       empty,
	input  logic       pop,
	output logic       kind,
	output logic [7:0] payload_byte,
	output logic       last_payload,
	output logic       checksum_bad,
	output logic [7:0] frame_length
);

	logic accept;
	logic op_push;
	op_t  op_in;
	op_t  op_out;
	logic q_full;
	logic q_empty;
	logic op_take;

	assign full   = q_full;
	assign accept = push && !q_full;

	cfp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.op_push (op_push),
		.op      (op_in)
	);

	cfp_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (op_push),
		.wr_data (op_in),
		.full    (q_full),
		.pop     (op_take),
		.rd_data (op_out),
		.empty   (q_empty)
	);

	cfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_avail     (!q_empty),
		.op           (op_out),
		.op_take      (op_take),
		.pop          (pop),
		.empty        (empty),
		.kind         (kind),
		.payload_byte (payload_byte),
		.last_payload (last_payload),
		.checksum_bad (checksum_bad),
		.frame_length (frame_length)
	);

endmodule : checksum_frame_parser_top

`default_nettype wire

[rtl/cfp_front.sv]
// Front end: tracks the frame position of each received byte and queues operations.
`default_nettype none

module cfp_front
	import cfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] rx_byte,
	output logic       op_push,
	output op_t        op
);

	typedef enum logic [2:0] {
		PH_START   = 3'd0,
		PH_LENGTH  = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_CHECK   = 3'd3,
		PH_END     = 3'd4
	} phase_t;

	phase_t     phase_q;
	logic [7:0] left_q;
	logic [7:0] len_q;

	// Classify the incoming word; only payload and checksum bytes produce work.
	always_comb begin
		op_push   = 1'b0;
		op.kind   = KIND_PAYLOAD;
		op.data   = rx_byte;
		op.last   = (left_q == 8'd1);
		op.length = len_q;
		unique case (phase_q)
			PH_PAYLOAD: begin
				op_push = accept;
			end
			PH_CHECK: begin
				op_push = accept;
				op.kind = KIND_STATUS;
				op.last = 1'b0;
			end
			default: begin
				op_push = 1'b0;
			end
		endcase
	end

	// Frame position, remaining payload count and announced length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			left_q  <= '0;
			len_q   <= '0;
		end else if (accept) begin
			unique case (phase_q)
				PH_LENGTH: begin
					len_q   <= rx_byte;
					left_q  <= rx_byte;
					phase_q <= (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
				end
				PH_PAYLOAD: begin
					left_q <= left_q - 8'd1;
					if (left_q == 8'd1) begin
						phase_q <= PH_CHECK;
					end
				end
				PH_CHECK: begin
					phase_q <= PH_END;
				end
				PH_END: begin
					phase_q <= PH_START;
				end
				default: begin
					phase_q <= PH_LENGTH;
				end
			endcase
		end
	end

	// While payload is expected, at least one payload byte must remain.
	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> left_q != 8'd0)
		else $error("payload phase with no bytes left");

endmodule : cfp_front

`default_nettype wire

[rtl/cfp_queue.sv]
// Short queue of operations between the front end and the back end.
`default_nettype none

module cfp_queue
	import cfp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  wr_data,
	output logic full,
	input  logic pop,
	output op_t  rd_data,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Storage words carry no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers wrap at the queue depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("operation queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("operation queue underflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("operation queue count out of range");

endmodule : cfp_queue

`default_nettype wire

[rtl/cfp_back.sv]
// Back end: sums payload, checks the checksum and holds the output word.
`default_nettype none

module cfp_back
	import cfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       op_avail,
	input  op_t        op,
	output logic       op_take,
	input  logic       pop,
	output logic       empty,
	output logic       kind,
	output logic [7:0] payload_byte,
	output logic       last_payload,
	output logic       checksum_bad,
	output logic [7:0] frame_length
);

	logic       out_valid_q;
	kind_t      kind_q;
	logic [7:0] data_q;
	logic       last_q;
	logic       bad_q;
	logic [7:0] len_q;
	logic [7:0] sum_q;

	// Take the next operation whenever the output register is free or being emptied.
	assign op_take = op_avail && (!out_valid_q || pop);

	assign empty        = !out_valid_q;
	assign kind         = kind_q;
	assign payload_byte = data_q;
	assign last_payload = last_q;
	assign checksum_bad = bad_q;
	assign frame_length = len_q;

	// Output valid flag and running checksum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sum_q       <= SUM_SEED;
		end else begin
			if (op_take) begin
				out_valid_q <= 1'b1;
				if (op.kind == KIND_STATUS) begin
					sum_q <= SUM_SEED;
				end else begin
					sum_q <= sum_q + op.data;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output word: a payload byte, or the frame status with the checksum verdict.
	always_ff @(posedge clk) begin
		if (op_take) begin
			kind_q <= op.kind;
			len_q  <= op.length;
			if (op.kind == KIND_STATUS) begin
				data_q <= 8'd0;
				last_q <= 1'b0;
				bad_q  <= (op.data != ~sum_q);
			end else begin
				data_q <= op.data;
				last_q <= op.last;
				bad_q  <= 1'b0;
			end
		end
	end

	// Every frame closes with its checksum, after which the sum starts afresh.
	a_sum_reseed: assert property (@(posedge clk) disable iff (!arst_n)
		op_take && op.kind == KIND_STATUS |=> sum_q == SUM_SEED)
		else $error("checksum not reseeded after status word");

endmodule : cfp_back

`default_nettype wire

[test/frame_parser_checker.sv]
// Checker for the frame parser: predicts each result word and compares it with the block's output.
`timescale 1ns / 100ps

module frame_parser_checker
	import cfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] rx_byte,
	input  logic       empty,
	input  logic       pop,
	input  logic       kind,
	input  logic [7:0] payload_byte,
	input  logic       last_payload,
	input  logic       checksum_bad,
	input  logic [7:0] frame_length,
	output int         fail_count,
	output int         pending,
	output logic       at_frame_start
);

	// Where the parser stands within the current frame.
	typedef enum logic [2:0] {
		AWAIT_START  = 3'd0,
		AWAIT_LENGTH = 3'd1,
		IN_PAYLOAD   = 3'd2,
		AWAIT_CHECK  = 3'd3,
		AWAIT_END    = 3'd4
	} parse_state_t;

	// One result word as it leaves the block.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
		logic       bad;
		logic [7:0] length;
	} parser_word_t;

	parse_state_t parse_state;
	logic [7:0]   bytes_owed;
	logic [7:0]   sum_acc;
	logic [7:0]   frame_len;
	parser_word_t due_words[$];
	parser_word_t want;
	parser_word_t got;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_state = AWAIT_START;
			bytes_owed = 8'd0;
			sum_acc = SUM_SEED;
			frame_len = 8'd0;
			due_words.delete();
		end else begin
			// Compare a word leaving the block with the oldest one predicted.
			if (pop && !empty) begin
				got.kind = kind_t'(kind);
				got.data = payload_byte;
				got.last = last_payload;
				got.bad = checksum_bad;
				got.length = frame_length;
				if (due_words.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected word kind=%b byte=%h last=%b bad=%b len=%0d",
						$time, got.kind, got.data, got.last, got.bad, got.length);
				end else begin
					want = due_words.pop_front();
					if (got !== want) begin
						fail_count++;
						$display("%0t: word mismatch, expected kind=%b byte=%h last=%b bad=%b len=%0d",
							$time, want.kind, want.data, want.last, want.bad, want.length);
						$display("%0t:                 actual kind=%b byte=%h last=%b bad=%b len=%0d",
							$time, got.kind, got.data, got.last, got.bad, got.length);
					end
				end
			end

			// Advance the frame state on each accepted byte and predict its word, if any.
			if (push && !full) begin
				case (parse_state)
					AWAIT_LENGTH: begin
						frame_len = rx_byte;
						bytes_owed = rx_byte;
						sum_acc = SUM_SEED;
						parse_state = (rx_byte == 8'd0) ? AWAIT_CHECK : IN_PAYLOAD;
					end
					IN_PAYLOAD: begin
						sum_acc = sum_acc + rx_byte;
						bytes_owed = bytes_owed - 8'd1;
						if (bytes_owed == 8'd0)
							parse_state = AWAIT_CHECK;
						want.kind = KIND_PAYLOAD;
						want.data = rx_byte;
						want.last = (bytes_owed == 8'd0);
						want.bad = 1'b0;
						want.length = frame_len;
						due_words.push_back(want);
					end
					AWAIT_CHECK: begin
						want.kind = KIND_STATUS;
						want.data = 8'd0;
						want.last = 1'b0;
						want.bad = (rx_byte != ~sum_acc);
						want.length = frame_len;
						due_words.push_back(want);
						parse_state = AWAIT_END;
					end
					AWAIT_END: begin
						parse_state = AWAIT_START;
					end
					default: begin
						parse_state = AWAIT_LENGTH;
					end
				endcase
			end
		end
		pending = due_words.size();
		at_frame_start = (parse_state == AWAIT_START);
	end

endmodule

[test/tb_top.sv]
// Testbench top for the checksum frame parser: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps

module tb_top
	import cfp_pkg::*;
;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] rx_byte = 8'd0;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic       kind;
	logic [7:0] payload_byte;
	logic       last_payload;
	logic       checksum_bad;
	logic [7:0] frame_length;
	int         fail_count;
	int         pending;
	logic       at_frame_start;

	int         tx_idle_pct = 31;
	int         rx_idle_pct = 70;
	int         words_sent = 0;
	int         frame_no = 0;
	logic [7:0] frame_body[$];

	checksum_frame_parser_top uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .rx_byte(rx_byte),
		.empty(empty), .pop(pop), .kind(kind), .payload_byte(payload_byte),
		.last_payload(last_payload), .checksum_bad(checksum_bad),
		.frame_length(frame_length)
	);

	frame_parser_checker checker_i (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .rx_byte(rx_byte),
		.empty(empty), .pop(pop), .kind(kind), .payload_byte(payload_byte),
		.last_payload(last_payload), .checksum_bad(checksum_bad),
		.frame_length(frame_length), .fail_count(fail_count), .pending(pending),
		.at_frame_start(at_frame_start)
	);

	// Clock with an 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The receiver stalls at random, changing pop at the falling edge.
	always @(negedge clk) begin
		pop = ($urandom_range(99) >= rx_idle_pct);
	end

	// Offer one word, with random idle cycles first, and hold it until it is taken.
	task automatic send_word(input logic [7:0] value);
		while ($urandom_range(99) < tx_idle_pct) begin
			push = 1'b0;
			rx_byte = 8'($urandom);
			@(negedge clk);
		end
		push = 1'b1;
		rx_byte = value;
		do @(posedge clk); while (full);
		words_sent++;
		@(negedge clk);
	endtask

	// Send a whole frame around frame_body; a non-zero flip spoils the checksum.
	task automatic send_frame(input logic [7:0] open_mark, input logic [7:0] close_mark,
			input logic [7:0] flip);
		logic [7:0] sum;
		sum = SUM_SEED;
		send_word(open_mark);
		send_word(8'(frame_body.size()));
		foreach (frame_body[i]) begin
			sum = sum + frame_body[i];
			send_word(frame_body[i]);
		end
		send_word(~sum ^ flip);
		send_word(close_mark);
	endtask

	// Stimulus: directed frames, then random frames with occasional line noise.
	initial begin
		int len;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty frames: the checksum byte is checked against 0x00.
		frame_body = {};
		send_frame(8'h00, 8'hFF, 8'h00);
		send_frame(8'hFF, 8'h00, 8'hFF);
		// Extreme payload values with good and bad checksums.
		frame_body = {8'hFF, 8'h00};
		send_frame(8'hAA, 8'h55, 8'h00);
		frame_body = {8'h80};
		send_frame(8'h55, 8'hAA, 8'h01);
		frame_body = {8'h01, 8'h7F, 8'hFE};
		send_frame(8'h7E, 8'h81, 8'h00);

		words_sent = 0;
		while (words_sent < 800) begin
			if (words_sent < 267) begin
				tx_idle_pct = 31;
				rx_idle_pct = 70;
			end else if (words_sent < 533) begin
				tx_idle_pct = 70;
				rx_idle_pct = 31;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			if ($urandom_range(99) < 6) begin
				// Noise that breaks framing, then small filler until the parser is back at a start.
				repeat ($urandom_range(1, 3)) send_word(8'($urandom));
				while (!at_frame_start)
					send_word(8'($urandom_range(0, 3)));
			end else begin
				if (frame_no == 20 || frame_no == 60)
					len = 255;
				else if ($urandom_range(99) < 10)
					len = $urandom_range(13, 64);
				else
					len = $urandom_range(0, 12);
				frame_body = {};
				repeat (len) frame_body.push_back(8'($urandom));
				send_frame(8'($urandom), 8'($urandom),
					($urandom_range(99) < 20) ? 8'($urandom_range(1, 255)) : 8'h00);
				frame_no++;
			end
		end

		// Drain every predicted word, then allow for the pipeline latency.
		push = 1'b0;
		rx_idle_pct = 0;
		wait (pending == 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

[checksum_frame_parser_top.f]
rtl/cfp_pkg.sv
rtl/cfp_front.sv
rtl/cfp_queue.sv
rtl/cfp_back.sv
rtl/checksum_frame_parser_top.sv
test/frame_parser_checker.sv
test/tb_top.sv
